// File: src/grm_pkg.sv
// Package for the graph reachability marker: sizes, state codes, control structs.
`timescale 1ns / 1ps
package grm_pkg;

  localparam int NODE_COUNT    = 1024;
  localparam int REFS_PER_NODE = 4;
  localparam int STACK_DEPTH   = 1024;

  localparam int NODE_W   = 10;  // node_index / child_index field width
  localparam int SLOT_W   = 2;   // slot_index field width
  localparam int MODE_W   = 2;
  localparam int CNT_W    = 11;  // visited_count field width

  localparam int REF_W    = (REFS_PER_NODE > 1) ? $clog2(REFS_PER_NODE) : 1;
  localparam int NADDR_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int EDGE_DEPTH = NODE_COUNT * REFS_PER_NODE;
  localparam int EADDR_W  = $clog2(EDGE_DEPTH);
  localparam int CLR_W    = EADDR_W;
  localparam int STK_AW   = $clog2(STACK_DEPTH);
  localparam int SP_W     = $clog2(STACK_DEPTH + 1);
  localparam int TOT_W    = $clog2(NODE_COUNT + 1);
  localparam int EDGE_W   = NODE_W + 1;  // {present, child}

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_ROOT = 2'd1,
    MODE_RUN  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_ROOT_RD,
    ST_ROOT_CHK,
    ST_POP,
    ST_EDGE_RD,
    ST_EDGE_CHK,
    ST_MARK_CHK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic capture;     // latch the input item
    logic clr_step;    // clear one edge slot and one mark
    logic edge_write;  // write the captured slot
    logic mark_rd;     // read a visited mark
    logic mark_set;    // mark, count and push
    logic use_child;   // mark address comes from the edge read data
    logic set_fresh;
    logic pop;         // read top of stack, decrement pointer
    logic slot_clr;
    logic slot_inc;
    logic edge_rd;     // read slot of the popped parent
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic  clr_done;
    logic  sp_zero;
    logic  mark_bit;
    logic  edge_present;
    logic  last_slot;
    logic  out_free;
    mode_t mode;
  } status_t;

endpackage

// File: src/graph_reachability_marker_unit.sv
// Top level of the depth-first mark engine with explicit work stack.
//
//   channel  direction  handshake              payload
//   in       into block in_valid / in_stall    mode node_index slot_index child_index child_present
//   out      out of it  out_valid / out_stall  visited_count newly_marked
//
// A run pops each stacked node, reads each of its edge slots and does one
// mark read per present child, marking and pushing unmarked children.
// After reset a sweep clears edge table and marks, one entry a cycle;
// in_stall stays high meanwhile.
// An item is taken while a result waits; a stalled output only holds the
// block when the next result is due.
`timescale 1ns / 1ps
module graph_reachability_marker_unit import grm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] mode,
  input  logic [NODE_W-1:0] node_index,
  input  logic [SLOT_W-1:0] slot_index,
  input  logic [NODE_W-1:0] child_index,
  input  logic              child_present,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CNT_W-1:0]  visited_count,
  output logic              newly_marked
);

  cmd_t    cmd;
  status_t status;

  grm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  grm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .mode          (mode),
    .node_index    (node_index),
    .slot_index    (slot_index),
    .child_index   (child_index),
    .child_present (child_present),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .visited_count (visited_count),
    .newly_marked  (newly_marked)
  );

endmodule

// File: src/grm_ctrl.sv
// Sequencer for clearing, loading, root marking and the depth-first walk.
`timescale 1ns / 1ps
module grm_ctrl import grm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (status.mode)
            MODE_LOAD: state_next = ST_LOAD;
            MODE_ROOT: state_next = ST_ROOT_RD;
            MODE_RUN:  state_next = ST_POP;
            default:   state_next = ST_RESP;
          endcase
        end
      end
      ST_LOAD:     state_next = ST_RESP;
      ST_ROOT_RD:  state_next = ST_ROOT_CHK;
      ST_ROOT_CHK: state_next = ST_RESP;
      ST_POP: begin
        state_next = status.sp_zero ? ST_RESP : ST_EDGE_RD;
      end
      ST_EDGE_RD:  state_next = ST_EDGE_CHK;
      ST_EDGE_CHK: begin
        if (status.edge_present) begin
          state_next = ST_MARK_CHK;
        end else begin
          state_next = status.last_slot ? ST_POP : ST_EDGE_RD;
        end
      end
      ST_MARK_CHK: begin
        state_next = status.last_slot ? ST_POP : ST_EDGE_RD;
      end
      ST_RESP: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_LOAD:    cmd.edge_write = 1'b1;
      ST_ROOT_RD: cmd.mark_rd = 1'b1;
      ST_ROOT_CHK: begin
        cmd.mark_set  = !status.mark_bit;
        cmd.set_fresh = !status.mark_bit;
      end
      ST_POP: begin
        cmd.pop      = !status.sp_zero;
        cmd.slot_clr = 1'b1;
      end
      ST_EDGE_RD: cmd.edge_rd = 1'b1;
      ST_EDGE_CHK: begin
        cmd.mark_rd   = status.edge_present;
        cmd.use_child = 1'b1;
        cmd.slot_inc  = !status.edge_present;
      end
      ST_MARK_CHK: begin
        cmd.mark_set  = !status.mark_bit;
        cmd.use_child = 1'b1;
        cmd.slot_inc  = 1'b1;
      end
      ST_RESP: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: src/grm_datapath.sv
// Edge table, visited marks, work stack, counters and the result register.
`timescale 1ns / 1ps
module grm_datapath import grm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [MODE_W-1:0] mode,
  input  logic [NODE_W-1:0] node_index,
  input  logic [SLOT_W-1:0] slot_index,
  input  logic [NODE_W-1:0] child_index,
  input  logic              child_present,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CNT_W-1:0]  visited_count,
  output logic              newly_marked
);

  logic [EDGE_W-1:0]  edge_mem [EDGE_DEPTH];
  logic               mark_mem [NODE_COUNT];
  logic [NODE_W-1:0]  stack_mem [STACK_DEPTH];

  logic [EDGE_W-1:0]  edge_rdata;
  logic               mark_rdata;
  logic [NODE_W-1:0]  stack_rdata;

  logic [NODE_W-1:0]  node_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [NODE_W-1:0]  child_r;
  logic               present_r;
  logic               fresh;

  logic [CLR_W-1:0]   clr_addr;
  logic [SP_W-1:0]    sp;
  logic [TOT_W-1:0]   total;
  logic [REF_W-1:0]   slot_cnt;

  logic               node_ok;
  logic               slot_ok;
  logic               child_ok;
  logic [NODE_W-1:0]  mark_node;
  logic               stack_full;
  logic [SP_W-1:0]    sp_dec;
  logic [EADDR_W-1:0] edge_waddr;
  logic [EDGE_W-1:0]  edge_wdata;
  logic               edge_we;
  logic [NADDR_W-1:0] mark_waddr;
  logic               mark_we;

  assign node_ok  = 32'(node_r) < NODE_COUNT;
  assign slot_ok  = 32'(slot_r) < REFS_PER_NODE;
  assign child_ok = 32'(child_r) < NODE_COUNT;

  // mark target: the root of a root item, or the child just read in the walk
  assign mark_node  = cmd.use_child ? edge_rdata[NODE_W-1:0] : node_r;
  assign stack_full = 32'(sp) >= STACK_DEPTH;
  assign sp_dec     = sp - SP_W'(1);

  always_comb begin
    edge_we    = 1'b0;
    edge_waddr = clr_addr[EADDR_W-1:0];
    edge_wdata = '0;
    if (cmd.clr_step) begin
      edge_we = 1'b1;
    end else if (cmd.edge_write && node_ok && slot_ok) begin
      edge_we    = 1'b1;
      edge_waddr = EADDR_W'(32'(node_r) * REFS_PER_NODE + 32'(slot_r));
      edge_wdata = (present_r && child_ok) ? {1'b1, child_r} : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    if (cmd.edge_rd) begin
      edge_rdata <= edge_mem[EADDR_W'(32'(stack_rdata) * REFS_PER_NODE + 32'(slot_cnt))];
    end
  end

  assign mark_we    = cmd.clr_step || cmd.mark_set;
  assign mark_waddr = cmd.clr_step ? clr_addr[NADDR_W-1:0] : mark_node[NADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_waddr] <= !cmd.clr_step;
    if (cmd.mark_rd) mark_rdata <= mark_mem[mark_node[NADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.mark_set && !stack_full) stack_mem[sp[STK_AW-1:0]] <= mark_node;
    if (cmd.pop) stack_rdata <= stack_mem[sp_dec[STK_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      node_r    <= node_index;
      slot_r    <= slot_index;
      child_r   <= child_index;
      present_r <= child_present;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      sp       <= '0;
      total    <= '0;
      slot_cnt <= '0;
      fresh    <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + CLR_W'(1);
      if (cmd.capture) fresh <= 1'b0;
      else if (cmd.set_fresh) fresh <= 1'b1;
      if (cmd.mark_set) begin
        total <= total + TOT_W'(1);
        if (!stack_full) sp <= sp + SP_W'(1);
      end else if (cmd.pop) begin
        sp <= sp_dec;
      end
      if (cmd.slot_clr) slot_cnt <= '0;
      else if (cmd.slot_inc) slot_cnt <= slot_cnt + REF_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      visited_count <= CNT_W'(total);
      newly_marked  <= fresh;
    end
  end

  assign status.clr_done     = clr_addr == CLR_W'(EDGE_DEPTH - 1);
  assign status.sp_zero      = sp == '0;
  assign status.mark_bit     = mark_rdata;
  assign status.edge_present = edge_rdata[EDGE_W-1];
  assign status.last_slot    = slot_cnt == REF_W'(REFS_PER_NODE - 1);
  assign status.out_free     = !out_valid || !out_stall;
  // decode in idle looks at the item being taken
  assign status.mode         = mode_t'(mode);

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    32'(sp) <= STACK_DEPTH)
    else $error("stack pointer beyond depth");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= NODE_COUNT)
    else $error("visited total beyond node count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> sp != '0)
    else $error("pop from empty stack");

  a_mark_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.mark_set |=> total == TOT_W'($past(total) + TOT_W'(1)))
    else $error("mark did not bump the total");

  a_no_load_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result register overwritten");

endmodule

// File: bench/tb.sv
// Self-checking testbench for graph_reachability_marker_unit: mark engine with work stack.
`timescale 1ns / 1ps
module tb;
  import grm_pkg::*;

  typedef struct {
    int unsigned      item_no;
    logic [CNT_W-1:0] count;
    logic             fresh;
  } visit_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  mode_t             mode;
  logic [NODE_W-1:0] node_index;
  logic [SLOT_W-1:0] slot_index;
  logic [NODE_W-1:0] child_index;
  logic              child_present;
  logic              out_valid;
  logic              out_stall;
  logic [CNT_W-1:0]  visited_count;
  logic              newly_marked;

  // shadow of the block's state
  bit                node_marked [NODE_COUNT];
  bit [EDGE_W-1:0]   edge_slot [EDGE_DEPTH];  // {present, child}
  int unsigned       walk_stack [$];
  int unsigned       mark_total;

  visit_result_t     visit_results_due [$];
  int unsigned       items_issued;
  int unsigned       mismatch_count;
  bit                quiet;                   // no gaps and no stalls while set
  int unsigned       stall_left;
  int unsigned       stall_draw;

  graph_reachability_marker_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .node_index    (node_index),
    .slot_index    (slot_index),
    .child_index   (child_index),
    .child_present (child_present),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .visited_count (visited_count),
    .newly_marked  (newly_marked)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void mark_node(int unsigned n);
    node_marked[n] = 1'b1;
    mark_total++;
    if (walk_stack.size() < STACK_DEPTH) walk_stack.push_back(n);
  endfunction

  // Field widths keep every index in range, so no range checks are needed here.
  function automatic void compute_visit_result();
    visit_result_t     r;
    int unsigned       parent;
    bit [EDGE_W-1:0]   ref_v;
    r.fresh = 1'b0;
    case (mode)
      MODE_LOAD: begin
        edge_slot[node_index * REFS_PER_NODE + slot_index] =
          child_present ? {1'b1, child_index} : '0;
      end
      MODE_ROOT: begin
        if (!node_marked[node_index]) begin
          mark_node(node_index);
          r.fresh = 1'b1;
        end
      end
      MODE_RUN: begin
        while (walk_stack.size() != 0) begin
          parent = walk_stack.pop_back();
          for (int s = 0; s < REFS_PER_NODE; s++) begin
            ref_v = edge_slot[parent * REFS_PER_NODE + s];
            if (ref_v[NODE_W] && !node_marked[ref_v[NODE_W-1:0]]) mark_node(ref_v[NODE_W-1:0]);
          end
        end
      end
      default: ;
    endcase
    r.item_no = items_issued;
    r.count   = mark_total[CNT_W-1:0];
    visit_results_due.push_back(r);
  endfunction

  task automatic check_visit_result();
    visit_result_t want;
    if (visit_results_due.size() == 0) begin
      report_mismatch($sformatf("result count=%0d fresh=%0d with no item outstanding",
                                visited_count, newly_marked));
    end else begin
      want = visit_results_due.pop_front();
      if (visited_count !== want.count)
        report_mismatch($sformatf("item %0d visited_count expected %0d got %0d",
                                  want.item_no, want.count, visited_count));
      if (newly_marked !== want.fresh)
        report_mismatch($sformatf("item %0d newly_marked expected %0d got %0d",
                                  want.item_no, want.fresh, newly_marked));
    end
  endtask

  // result side: check each taken result, then draw a random stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      check_visit_result();
      stall_draw = quiet ? 0 : $urandom_range(0, 10);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  // Returns at the edge where the item is taken; valid stays high unless a gap follows.
  task automatic send_item(mode_t m, int unsigned node, int unsigned slot,
                           int unsigned child, bit present);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= m;
    node_index    <= node[NODE_W-1:0];
    slot_index    <= slot[SLOT_W-1:0];
    child_index   <= child[NODE_W-1:0];
    child_present <= present;
    do @(posedge clk); while (in_stall);
    items_issued++;
    compute_visit_result();
  endtask

  // drops valid first so the last item is not taken again while waiting
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (visit_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic pick_fresh_nodes(int unsigned want, ref int unsigned group [$]);
    int unsigned n;
    int unsigned tries;
    bit          taken;
    group.delete();
    tries = 0;
    while (group.size() < want && tries < 300) begin
      n = $urandom_range(0, NODE_COUNT - 1);
      tries++;
      taken = node_marked[n];
      foreach (group[i]) if (group[i] == n) taken = 1'b1;
      if (!taken) group.push_back(n);
    end
  endtask

  // unused mode, empty run, repeated root, null and self references, cycles
  task automatic test_corner_items();
    send_item(MODE_NONE, NODE_COUNT - 1, REFS_PER_NODE - 1, NODE_COUNT - 1, 1'b1);
    send_item(MODE_RUN, 0, 0, 0, 1'b0);
    send_item(MODE_ROOT, 0, 0, 0, 1'b0);
    send_item(MODE_ROOT, 0, 3, 1023, 1'b1);
    send_item(MODE_LOAD, 1023, 3, 1023, 1'b1);
    send_item(MODE_LOAD, 1023, 0, 0, 1'b1);
    send_item(MODE_LOAD, 1023, 1, 512, 1'b0);
    send_item(MODE_LOAD, 512, 2, 1, 1'b1);
    send_item(MODE_LOAD, 1, 0, 512, 1'b1);
    send_item(MODE_LOAD, 1023, 2, 512, 1'b1);
    send_item(MODE_LOAD, 1023, 2, 512, 1'b0);  // overwrite with null
    send_item(MODE_ROOT, 1023, 1, 682, 1'b1);
    send_item(MODE_RUN, 341, 2, 341, 1'b1);
    send_item(MODE_ROOT, 512, 0, 0, 1'b0);
    send_item(MODE_NONE, 0, 0, 0, 1'b0);
    send_item(MODE_RUN, 0, 0, 0, 1'b0);
    send_item(MODE_LOAD, 2, 0, 3, 1'b1);
    send_item(MODE_LOAD, 2, 1, 4, 1'b1);
    send_item(MODE_LOAD, 2, 2, 5, 1'b1);
    send_item(MODE_LOAD, 2, 3, 6, 1'b1);
    send_item(MODE_LOAD, 3, 3, 2, 1'b1);      // back edge to parent
    send_item(MODE_LOAD, 6, 1, 1023, 1'b1);   // edge into a marked node
    send_item(MODE_ROOT, 2, 0, 0, 1'b0);
    send_item(MODE_RUN, 0, 0, 0, 1'b0);
  endtask

  // long chain loaded back to back, walked after the pipeline has emptied
  task automatic test_deep_chain();
    int unsigned chain [$];
    pick_fresh_nodes($urandom_range(20, 40), chain);
    quiet = 1'b1;
    for (int i = 1; i < chain.size(); i++)
      send_item(MODE_LOAD, chain[i-1], $urandom_range(0, 3), chain[i], 1'b1);
    quiet = 1'b0;
    wait_for_results();
    send_item(MODE_ROOT, chain[0], 0, 0, 1'b0);
    send_item(MODE_RUN, 0, 0, 0, 1'b0);
  endtask

  // small random trees with cross edges, then root and run; some noise between
  task automatic test_random_structures(int unsigned item_goal);
    int unsigned group [$];
    int unsigned src;
    int unsigned dst;
    while (items_issued < item_goal) begin
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        7: send_item(mode_t'($urandom_range(0, 3)), $urandom_range(0, NODE_COUNT - 1),
                     $urandom_range(0, 3), $urandom_range(0, NODE_COUNT - 1),
                     $urandom_range(0, 1) == 1);
        8: send_item(MODE_ROOT, $urandom_range(0, NODE_COUNT - 1), $urandom_range(0, 3),
                     $urandom_range(0, NODE_COUNT - 1), $urandom_range(0, 1) == 1);
        9: send_item(MODE_RUN, $urandom_range(0, NODE_COUNT - 1), $urandom_range(0, 3),
                     $urandom_range(0, NODE_COUNT - 1), $urandom_range(0, 1) == 1);
        default: begin
          pick_fresh_nodes($urandom_range(2, 12), group);
          if (group.size() != 0) begin
            for (int i = 1; i < group.size(); i++)
              send_item(MODE_LOAD, group[$urandom_range(0, i - 1)], $urandom_range(0, 3),
                        group[i], 1'b1);
            repeat ($urandom_range(0, 4)) begin
              src = group[$urandom_range(0, group.size() - 1)];
              if ($urandom_range(0, 3) == 0) dst = $urandom_range(0, NODE_COUNT - 1);
              else dst = group[$urandom_range(0, group.size() - 1)];
              send_item(MODE_LOAD, src, $urandom_range(0, 3), dst, $urandom_range(0, 4) != 0);
            end
            send_item(MODE_ROOT, group[0], $urandom_range(0, 3),
                      $urandom_range(0, NODE_COUNT - 1), $urandom_range(0, 1) == 1);
            if ($urandom_range(0, 3) == 0)
              send_item(MODE_ROOT, group[$urandom_range(0, group.size() - 1)], 0, 0, 1'b0);
            // occasionally leave the roots on the stack for a later run
            if ($urandom_range(0, 7) != 0) send_item(MODE_RUN, 0, 0, 0, 1'b0);
          end
        end
      endcase
    end
    quiet = 1'b0;
  endtask

  // random edges across the whole table, then a few roots and one walk
  task automatic test_dense_flood();
    repeat (70)
      send_item(MODE_LOAD, $urandom_range(0, NODE_COUNT - 1), $urandom_range(0, 3),
                $urandom_range(0, NODE_COUNT - 1), $urandom_range(0, 3) != 0);
    repeat (6)
      send_item(MODE_ROOT, $urandom_range(0, NODE_COUNT - 1), 0, 0, 1'b0);
    send_item(MODE_RUN, 0, 0, 0, 1'b0);
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    mode          = MODE_LOAD;
    node_index    = '0;
    slot_index    = '0;
    child_index   = '0;
    child_present = 1'b0;
    out_stall     = 1'b0;
    quiet         = 1'b0;
    mark_total    = 0;
    items_issued  = 0;
    mismatch_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_corner_items();
    test_deep_chain();
    test_random_structures(340);
    test_dense_flood();
    in_valid <= 1'b0;
    wait_for_results();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("graph_reachability_marker_unit verification clean");
    end else begin
      $display("graph_reachability_marker_unit verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("graph_reachability_marker_unit verification failed");
    $finish;
  end

endmodule

// File: sim.f
src/grm_pkg.sv
src/grm_ctrl.sv
src/grm_datapath.sv
src/graph_reachability_marker_unit.sv
bench/tb.sv
